[rtl/core/tlbc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbc_pkg
// shared types and constants of the clock-replacement tlb
// ---------------------------------------------------------------------------
package tlbc_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_PAGE_BITS  = 20;
    localparam int DEF_FRAME_BITS = 20;

    // fixed widths of the register and of the slot field
    localparam int CFG_W  = 5;
    localparam int SLOT_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic touch_hit;
        logic fill_free;
        logic start_sweep;
        logic sweep_step;
        logic fill_hand;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic free;
        logic used_at_hand;
    } t_sts;

endpackage

[rtl/core/tlbc_req_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbc_req_if
// request channel: page, access kind and walk frame
// ---------------------------------------------------------------------------
interface tlbc_req_if #(
    parameter int PAGE_BITS  = tlbc_pkg::DEF_PAGE_BITS,
    parameter int FRAME_BITS = tlbc_pkg::DEF_FRAME_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [PAGE_BITS-1:0]  virtual_page;
    logic                  is_write;
    logic [FRAME_BITS-1:0] walk_frame;

    modport source (output valid, output virtual_page, output is_write,
                    output walk_frame, input ready);
    modport sink   (input valid, input virtual_page, input is_write,
                    input walk_frame, output ready);
endinterface

[rtl/core/tlbc_rsp_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbc_rsp_if
// response channel: frame, hit flag and slot
// ---------------------------------------------------------------------------
interface tlbc_rsp_if #(
    parameter int FRAME_BITS = tlbc_pkg::DEF_FRAME_BITS
) ();
    logic                        valid;
    logic                        ready;
    logic [FRAME_BITS-1:0]       frame;
    logic                        hit;
    logic [tlbc_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output frame, output hit, output slot,
                    input ready);
    modport sink   (input valid, input frame, input hit, input slot,
                    output ready);
endinterface

[rtl/core/tlb_clock_replacement.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlb_clock_replacement
// fully associative tlb with clock replacement
// ---------------------------------------------------------------------------
// usage
//   i_req carries one access per beat: virtual page, write flag and the
//   frame a page-table walk would give. o_rsp returns one beat per access:
//   frame, hit flag and slot of the entry hit or filled.
//   i_cfg_we / i_cfg_data write entries_in_use; write only while idle.
// sequence
//   hit or fill of a free entry: the request is captured, then the entry is
//   touched or filled, then the result is loaded; a new request is taken
//   in the cycle the result is loaded.
//   replacement: the hand passes used entries before the fill; the sweep
//   clears one used bit per cycle.
// reset
//   all entries invalid, hand at 0, entries_in_use at the depth, capped at 31.
// stall
//   the result sits in an output register; the next request is taken and
//   worked up to the result point, then waits until the register frees.
// ---------------------------------------------------------------------------
module tlb_clock_replacement #(
    parameter int ENTRIES    = tlbc_pkg::DEF_ENTRIES,
    parameter int PAGE_BITS  = tlbc_pkg::DEF_PAGE_BITS,
    parameter int FRAME_BITS = tlbc_pkg::DEF_FRAME_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tlbc_pkg::CFG_W-1:0] i_cfg_data,
    tlbc_req_if.sink                   i_req,
    tlbc_rsp_if.source                 o_rsp
);
    import tlbc_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    tlbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid)
    );

    // entries, tag compare, hand, result register
    tlbc_dp #(
        .ENTRIES    (ENTRIES),
        .PAGE_BITS  (PAGE_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_virtual_page (i_req.virtual_page),
        .i_is_write     (i_req.is_write),
        .i_walk_frame   (i_req.walk_frame),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_frame        (o_rsp.frame),
        .o_hit          (o_rsp.hit),
        .o_slot         (o_rsp.slot)
    );

endmodule

[rtl/core/tlbc_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbc_ctrl
// sequencer: lookup decision, clock sweep and result hand-off
// ---------------------------------------------------------------------------
module tlbc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_rsp_ready,
    input  tlbc_pkg::t_sts i_sts,
    output tlbc_pkg::t_cmd o_cmd,
    output logic           o_req_ready,
    output logic           o_rsp_valid
);
    import tlbc_pkg::*;

    t_state r_state, n_state;
    logic   r_rsp_valid;
    logic   out_free;

    assign out_free = !r_rsp_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_sts.hit || i_sts.free) n_state = ST_DONE;
                else                         n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (!i_sts.used_at_hand) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = i_req_valid ? ST_DECIDE : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // no beat is taken while reset is held
                o_req_ready   = i_rst_n;
                o_cmd.capture = i_req_valid && i_rst_n;
            end
            ST_DECIDE: begin
                if (i_sts.hit)       o_cmd.touch_hit   = 1'b1;
                else if (i_sts.free) o_cmd.fill_free   = 1'b1;
                else                 o_cmd.start_sweep = 1'b1;
            end
            ST_SWEEP: begin
                if (i_sts.used_at_hand) o_cmd.sweep_step = 1'b1;
                else                    o_cmd.fill_hand  = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = out_free;
                o_req_ready    = out_free;
                o_cmd.capture  = out_free && i_req_valid;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

[rtl/core/tlbc_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbc_dp
// entry store, tag compare, clock hand and result register
// ---------------------------------------------------------------------------
module tlbc_dp #(
    parameter int ENTRIES    = tlbc_pkg::DEF_ENTRIES,
    parameter int PAGE_BITS  = tlbc_pkg::DEF_PAGE_BITS,
    parameter int FRAME_BITS = tlbc_pkg::DEF_FRAME_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tlbc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [PAGE_BITS-1:0]        i_virtual_page,
    input  logic                        i_is_write,
    input  logic [FRAME_BITS-1:0]       i_walk_frame,
    input  tlbc_pkg::t_cmd              i_cmd,
    output tlbc_pkg::t_sts              o_sts,
    output logic [FRAME_BITS-1:0]       o_frame,
    output logic                        o_hit,
    output logic [tlbc_pkg::SLOT_W-1:0] o_slot
);
    import tlbc_pkg::*;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CMP_W   = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
    localparam int CFG_RST = (ENTRIES > 31) ? 31 : ENTRIES;

    // entry state
    logic [PAGE_BITS-1:0]  r_page [ENTRIES];
    logic [FRAME_BITS-1:0] r_frame_mem [ENTRIES];
    logic [ENTRIES-1:0]    r_valid, r_used, r_dirty;
    logic [IDX_W-1:0]      r_hand;
    logic [CFG_W-1:0]      r_cfg;

    // captured access
    logic [PAGE_BITS-1:0]  r_vpage;
    logic                  r_write;
    logic [FRAME_BITS-1:0] r_walk;
    logic [ENTRIES-1:0]    r_hit_vec, r_free_vec;

    logic [FRAME_BITS-1:0] r_rdata;
    logic [IDX_W-1:0]      r_pick;
    logic                  r_is_hit;

    logic [FRAME_BITS-1:0] r_out_frame;
    logic                  r_out_hit;
    logic [SLOT_W-1:0]     r_out_slot;

    logic [CMP_W-1:0]      active_cnt;
    logic [ENTRIES-1:0]    in_range, hit_vec, free_vec;
    logic [IDX_W-1:0]      hit_idx, free_idx, fill_idx, hand_start, hand_step;
    logic                  fill;

    // zero acts as one, values above the depth act as the depth
    always_comb begin
        if (r_cfg == '0) begin
            active_cnt = CMP_W'(1);
        end else if (CMP_W'(r_cfg) > CMP_W'(ENTRIES)) begin
            active_cnt = CMP_W'(ENTRIES);
        end else begin
            active_cnt = CMP_W'(r_cfg);
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            in_range[i] = CMP_W'(i) < active_cnt;
            hit_vec[i]  = r_valid[i] && (r_page[i] == i_virtual_page) && in_range[i];
            free_vec[i] = !r_valid[i] && in_range[i];
        end
    end

    // lowest set bit wins
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_hit_vec[i])  hit_idx  = IDX_W'(i);
            if (r_free_vec[i]) free_idx = IDX_W'(i);
        end
    end

    assign hand_start = (CMP_W'(r_hand) >= active_cnt) ? '0 : r_hand;
    assign hand_step  = (CMP_W'(r_hand) + CMP_W'(1) == active_cnt) ? '0
                                                                   : r_hand + 1'b1;
    assign fill       = i_cmd.fill_free || i_cmd.fill_hand;
    assign fill_idx   = i_cmd.fill_free ? free_idx : r_hand;

    assign o_sts.hit          = |r_hit_vec;
    assign o_sts.free         = |r_free_vec;
    assign o_sts.used_at_hand = r_used[r_hand];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            r_dirty <= '0;
            r_hand  <= '0;
            r_cfg   <= CFG_W'(CFG_RST);
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (fill) begin
                r_valid[fill_idx] <= 1'b1;
                r_used[fill_idx]  <= 1'b1;
                r_dirty[fill_idx] <= r_write;
            end
            if (i_cmd.touch_hit) begin
                r_used[hit_idx] <= 1'b1;
                if (r_write) r_dirty[hit_idx] <= 1'b1;
            end
            if (i_cmd.start_sweep) r_hand <= hand_start;
            if (i_cmd.sweep_step) begin
                r_used[r_hand] <= 1'b0;
                r_hand         <= hand_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vpage    <= i_virtual_page;
            r_write    <= i_is_write;
            r_walk     <= i_walk_frame;
            r_hit_vec  <= hit_vec;
            r_free_vec <= free_vec;
        end
        if (fill) begin
            r_page[fill_idx]      <= r_vpage;
            r_frame_mem[fill_idx] <= r_walk;
            r_pick                <= fill_idx;
            r_is_hit              <= 1'b0;
        end
        if (i_cmd.touch_hit) begin
            r_rdata  <= r_frame_mem[hit_idx];
            r_pick   <= hit_idx;
            r_is_hit <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_frame <= r_is_hit ? r_rdata : r_walk;
            r_out_hit   <= r_is_hit;
            r_out_slot  <= SLOT_W'(r_pick);
        end
    end

    assign o_frame = r_out_frame;
    assign o_hit   = r_out_hit;
    assign o_slot  = r_out_slot;

endmodule

[tb/tlb_clock_replacement_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlb_clock_replacement_tb
// self-checking bench for the clock-replacement tlb
// ---------------------------------------------------------------------------
// a queue of pending beats and register writes is built up front: a short
// directed run over the corner cases, then random phases, each under its
// own entry count. a clocked driver presents them, a clocked monitor takes
// responses, and an in-bench tlb model predicts every response at the
// request beat. idling runs in three phases: slow receiver, slow sender, none.
// ---------------------------------------------------------------------------
module tlb_clock_replacement_tb;

    localparam int N_ENTRIES   = tlbc_pkg::DEF_ENTRIES;
    localparam int PAGE_W      = tlbc_pkg::DEF_PAGE_BITS;
    localparam int FRAME_W     = tlbc_pkg::DEF_FRAME_BITS;
    localparam int CFG_W       = tlbc_pkg::CFG_W;
    localparam int SLOT_W      = tlbc_pkg::SLOT_W;
    localparam int STALL_LIMIT = 2000;
    localparam int END_DRAIN   = 24;
    localparam int PHASE_BEATS = 90;
    localparam int N_PHASES    = 15;
    localparam int POOL_SIZE   = 32;

    // what the pending queue holds: a request beat or a register write
    typedef enum logic {
        PEND_ACCESS,
        PEND_CFG
    } pend_kind_e;

    typedef struct {
        pend_kind_e          kind;
        logic [PAGE_W-1:0]   page;
        logic                wr;
        logic [FRAME_W-1:0]  walk;
        logic [CFG_W-1:0]    cfg;
        int                  src_idle_pct;
        int                  snk_idle_pct;
    } pend_item_t;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
    } tlb_result_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    tlbc_req_if #(.PAGE_BITS(PAGE_W), .FRAME_BITS(FRAME_W)) req_bus ();
    tlbc_rsp_if #(.FRAME_BITS(FRAME_W))                     rsp_bus ();

    tlb_clock_replacement #(
        .ENTRIES    (N_ENTRIES),
        .PAGE_BITS  (PAGE_W),
        .FRAME_BITS (FRAME_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    // stimulus and scoreboard storage
    pend_item_t  pending[$];
    tlb_result_t expected_rsp[$];

    // model state of the tlb
    logic [PAGE_W-1:0]  tlb_page  [N_ENTRIES];
    logic [FRAME_W-1:0] tlb_frame [N_ENTRIES];
    bit                 tlb_valid [N_ENTRIES];
    bit                 tlb_used  [N_ENTRIES];
    bit                 tlb_dirty [N_ENTRIES];
    int                 hand_pos;
    logic [CFG_W-1:0]   entries_cfg;

    // beat counters, one writer each, so the driver can tell when all is home
    int req_beats;
    int rsp_beats;
    int sink_idle_pct;
    int mismatch_count;
    int stall_cycles;

    // idling applied to items as they are queued
    int cur_src_pct;
    int cur_snk_pct;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of one access: search, fill or clock sweep, then mark the entry
    function automatic tlb_result_t translate_access(input logic [PAGE_W-1:0]  page,
                                                     input logic               wr,
                                                     input logic [FRAME_W-1:0] walk);
        tlb_result_t res;
        int          n;
        int          pick;
        int          h;
        int          steps;
        bit          matched;
        bit          free_found;
        // a count of zero acts as one, above the depth acts as the depth
        if (entries_cfg == 0) begin
            n = 1;
        end else if (entries_cfg > N_ENTRIES) begin
            n = N_ENTRIES;
        end else begin
            n = int'(entries_cfg);
        end
        matched    = 1'b0;
        free_found = 1'b0;
        pick       = 0;
        // lowest matching entry wins when a page sits in more than one
        for (int k = 0; k < n; k++) begin
            if (!matched && tlb_valid[k] && tlb_page[k] == page) begin
                matched = 1'b1;
                pick    = k;
            end
        end
        if (matched) begin
            res.frame = tlb_frame[pick];
        end else begin
            res.frame = walk;
            for (int k = 0; k < n; k++) begin
                if (!free_found && !tlb_valid[k]) begin
                    free_found = 1'b1;
                    pick       = k;
                end
            end
            if (!free_found) begin
                // hand left beyond a lowered count restarts at entry 0
                h     = (hand_pos >= n) ? 0 : hand_pos;
                steps = 0;
                while (steps < n && tlb_used[h]) begin
                    tlb_used[h] = 1'b0;
                    h           = (h + 1) % n;
                    steps++;
                end
                hand_pos = h;
                pick     = h;
            end
            tlb_page[pick]  = page;
            tlb_frame[pick] = walk;
            tlb_valid[pick] = 1'b1;
            tlb_dirty[pick] = 1'b0;
        end
        tlb_used[pick] = 1'b1;
        if (wr) begin
            tlb_dirty[pick] = 1'b1;
        end
        res.hit  = matched;
        res.slot = SLOT_W'(pick);
        return res;
    endfunction

    task automatic queue_access(input logic [PAGE_W-1:0]  page,
                                input logic               wr,
                                input logic [FRAME_W-1:0] walk);
        pend_item_t it;
        it.kind         = PEND_ACCESS;
        it.page         = page;
        it.wr           = wr;
        it.walk         = walk;
        it.cfg          = '0;
        it.src_idle_pct = cur_src_pct;
        it.snk_idle_pct = cur_snk_pct;
        pending.push_back(it);
    endtask

    task automatic queue_cfg(input logic [CFG_W-1:0] value);
        pend_item_t it;
        it.kind         = PEND_CFG;
        it.page         = '0;
        it.wr           = 1'b0;
        it.walk         = '0;
        it.cfg          = value;
        it.src_idle_pct = cur_src_pct;
        it.snk_idle_pct = cur_snk_pct;
        pending.push_back(it);
    endtask

    // driver: request beats and register writes from the pending queue
    always @(posedge i_clk) begin : drive_proc
        pend_item_t       head;
        logic             hold;
        logic             nxt_valid;
        logic             nxt_we;
        logic [CFG_W-1:0] nxt_data;
        nxt_we   = 1'b0;
        nxt_data = '0;
        if (!i_rst_n) begin
            for (int k = 0; k < N_ENTRIES; k++) begin
                tlb_page[k]  = '0;
                tlb_frame[k] = '0;
                tlb_valid[k] = 1'b0;
                tlb_used[k]  = 1'b0;
                tlb_dirty[k] = 1'b0;
            end
            hand_pos      = 0;
            entries_cfg   = CFG_W'(N_ENTRIES);
            req_bus.valid <= 1'b0;
            cfg_we        <= 1'b0;
            req_beats     <= 0;
        end else begin
            // predict at the request beat, in order of acceptance
            if (req_bus.valid && req_bus.ready) begin
                expected_rsp.push_back(translate_access(req_bus.virtual_page,
                                                        req_bus.is_write,
                                                        req_bus.walk_frame));
                req_beats <= req_beats + 1;
            end
            if (cfg_we) begin
                entries_cfg = cfg_data;
            end
            hold      = req_bus.valid && !req_bus.ready;
            nxt_valid = hold;
            if (!hold && pending.size() > 0) begin
                head = pending[0];
                if (head.kind == PEND_CFG) begin
                    // register writes only once the block has drained
                    nxt_valid = 1'b0;
                    if (!req_bus.valid && !cfg_we && req_beats == rsp_beats) begin
                        nxt_we   = 1'b1;
                        nxt_data = head.cfg;
                        void'(pending.pop_front());
                    end
                end else if ($urandom_range(0, 99) >= head.src_idle_pct) begin
                    nxt_valid            = 1'b1;
                    req_bus.virtual_page <= head.page;
                    req_bus.is_write     <= head.wr;
                    req_bus.walk_frame   <= head.walk;
                    sink_idle_pct        <= head.snk_idle_pct;
                    void'(pending.pop_front());
                end else begin
                    nxt_valid = 1'b0;
                end
            end
            req_bus.valid <= nxt_valid;
            cfg_we        <= nxt_we;
            if (nxt_we) begin
                cfg_data <= nxt_data;
            end
        end
    end

    // monitor: random backpressure, compare each response beat in order
    always @(posedge i_clk) begin : mon_proc
        tlb_result_t exp_r;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            rsp_beats     <= 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                rsp_beats <= rsp_beats + 1;
                if (expected_rsp.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected response: expected none actual frame %h hit %b slot %0d",
                             $time, rsp_bus.frame, rsp_bus.hit, rsp_bus.slot);
                end else begin
                    exp_r = expected_rsp.pop_front();
                    if (rsp_bus.frame !== exp_r.frame) begin
                        mismatch_count++;
                        $display("%0t frame mismatch: expected %h actual %h",
                                 $time, exp_r.frame, rsp_bus.frame);
                    end
                    if (rsp_bus.hit !== exp_r.hit) begin
                        mismatch_count++;
                        $display("%0t hit mismatch: expected %b actual %b",
                                 $time, exp_r.hit, rsp_bus.hit);
                    end
                    if (rsp_bus.slot !== exp_r.slot) begin
                        mismatch_count++;
                        $display("%0t slot mismatch: expected %0d actual %0d",
                                 $time, exp_r.slot, rsp_bus.slot);
                    end
                end
            end
            rsp_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // watchdog: too long without any beat or register write
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
                     || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stim_proc
        logic [PAGE_W-1:0] page_pool [POOL_SIZE];
        logic [PAGE_W-1:0] pg;
        int                cfg_plan [N_PHASES];
        int                n_eff;
        int                pool_used;
        int                rand_count;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        sink_idle_pct  = 0;
        req_bus.valid        = 1'b0;
        req_bus.virtual_page = '0;
        req_bus.is_write     = 1'b0;
        req_bus.walk_frame   = '0;
        rsp_bus.ready        = 1'b0;

        cfg_plan = '{16, 3, 9, 1, 0, 31, 17, 5, 2, 12, 16, 7, 4, 15, 8};
        for (int k = 0; k < POOL_SIZE; k++) begin
            page_pool[k] = PAGE_W'($urandom);
        end

        // first idling phase: slow receiver
        cur_src_pct = 27;
        cur_snk_pct = 84;

        // directed: extremes of page and frame, hits, full fill
        queue_cfg(CFG_W'(16));
        queue_access('0, 1'b0, '0);
        queue_access('1, 1'b1, '1);
        queue_access('0, 1'b0, FRAME_W'(20'h12345));
        queue_access('1, 1'b1, '0);
        for (int k = 2; k < N_ENTRIES; k++) begin
            queue_access(PAGE_W'(20'h00100 + k), k[0], FRAME_W'(20'hA5A50 ^ k));
        end
        // all entries valid and used: sweep goes a full round
        queue_access(PAGE_W'(20'hABCDE), 1'b1, FRAME_W'(20'h5A5A5));
        queue_access(PAGE_W'(20'h00105), 1'b0, FRAME_W'(20'h00001));
        // page held beyond the count is not seen, so it lands twice
        queue_cfg(CFG_W'(2));
        queue_access(PAGE_W'(20'h00105), 1'b1, FRAME_W'(20'h77777));
        queue_cfg(CFG_W'(16));
        queue_access(PAGE_W'(20'h00105), 1'b0, FRAME_W'(20'h00002));
        // zero count acts as one, hand now beyond the count
        queue_cfg(CFG_W'(0));
        queue_access(PAGE_W'(20'h54321), 1'b0, FRAME_W'(20'h0F0F0));
        queue_access(PAGE_W'(20'h54321), 1'b1, FRAME_W'(20'hF0F0F));
        // count above the depth acts as the depth
        queue_cfg(CFG_W'(31));
        queue_access(PAGE_W'(20'h00107), 1'b0, FRAME_W'(20'h33333));

        // random phases: pages mostly from a pool sized near the count
        rand_count = 0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            queue_cfg(CFG_W'(cfg_plan[ph]));
            n_eff = (cfg_plan[ph] == 0) ? 1 :
                    (cfg_plan[ph] > N_ENTRIES) ? N_ENTRIES : cfg_plan[ph];
            repeat ($urandom_range(2, 10)) begin
                page_pool[$urandom_range(0, POOL_SIZE - 1)] = PAGE_W'($urandom);
            end
            pool_used = n_eff + $urandom_range(0, 6);
            if (pool_used > POOL_SIZE) begin
                pool_used = POOL_SIZE;
            end
            repeat (PHASE_BEATS) begin
                if (rand_count < 450) begin
                    cur_src_pct = 27;
                    cur_snk_pct = 84;
                end else if (rand_count < 900) begin
                    cur_src_pct = 84;
                    cur_snk_pct = 27;
                end else begin
                    cur_src_pct = 0;
                    cur_snk_pct = 0;
                end
                if ($urandom_range(0, 99) < 80) begin
                    pg = page_pool[$urandom_range(0, pool_used - 1)];
                end else begin
                    pg = PAGE_W'($urandom);
                end
                queue_access(pg, 1'($urandom_range(0, 1)), FRAME_W'($urandom));
                rand_count++;
            end
        end

        // synchronous reset, then let the driver run
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (pending.size() != 0 || req_bus.valid || cfg_we || req_beats != rsp_beats) begin
            @(posedge i_clk);
        end
        repeat (END_DRAIN) @(posedge i_clk);

        if (expected_rsp.size() != 0) begin
            mismatch_count++;
            $display("%0t missing responses: expected %0d actual 0",
                     $time, expected_rsp.size());
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/tlbc_pkg.sv
rtl/core/tlbc_req_if.sv
rtl/core/tlbc_rsp_if.sv
rtl/core/tlbc_ctrl.sv
rtl/core/tlbc_dp.sv
rtl/core/tlb_clock_replacement.sv
tb/tlb_clock_replacement_tb.sv
